### design/polar_complex_arith_unit_macros.svh
// assertion macros for the polar complex unit
`ifndef POLAR_COMPLEX_ARITH_UNIT_MACROS_SVH
`define POLAR_COMPLEX_ARITH_UNIT_MACROS_SVH

// cond now implies past_cond as $past returns it for the given depth
`define CPA_ASSERT_PAST(label, cond, past_cond, depth) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (cond) |-> $past(past_cond, depth)) \
    else $error("polar complex unit: result does not match its request");

// plain same-cycle implication
`define CPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polar complex unit: inconsistent result word");

`endif

### design/cpa_pkg.sv
`default_nettype none
package cpa_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int GUARD = 16;
  localparam int CW = 52;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] KGAIN = 32'd2608131496;
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;

  localparam logic [3:0] ACT_FROM_RECT = 4'd0;
  localparam logic [3:0] ACT_TO_RECT = 4'd1;
  localparam logic [3:0] ACT_EQUAL = 4'd2;
  localparam logic [3:0] ACT_CONJ = 4'd3;
  localparam logic [3:0] ACT_NEGATE = 4'd4;
  localparam logic [3:0] ACT_INVERSE = 4'd5;
  localparam logic [3:0] ACT_ADD = 4'd6;
  localparam logic [3:0] ACT_SUB = 4'd7;
  localparam logic [3:0] ACT_MUL = 4'd8;
  localparam logic [3:0] ACT_DIV = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [3:0]  act;
    logic [63:0] prod;
    logic [31:0] mag;
    logic [31:0] ang;
    logic        eq;
    logic        dz;
  } cpa_ctrl_t;

  // atan(2^-i) as binary angle
  function automatic logic [31:0] arc_tab(input int i);
    logic [31:0] r;
    unique case (i)
      0: r = 32'h20000000;
      1: r = 32'h12E4051E;
      2: r = 32'h09FB385B;
      3: r = 32'h051111D4;
      4: r = 32'h028B0D43;
      5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;
      7: r = 32'h00517C55;
      8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/cpa_cordic.sv
`default_nettype none
module cpa_cordic #(
  parameter int STEPS = cpa_pkg::CORDIC_STEPS_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic                           clk,
  input  logic signed [cpa_pkg::CW-1:0]  x_in,
  input  logic signed [cpa_pkg::CW-1:0]  y_in,
  input  logic        [31:0]             z_in,
  output logic signed [cpa_pkg::CW-1:0]  x_out,
  output logic signed [cpa_pkg::CW-1:0]  y_out,
  output logic        [31:0]             z_out,
  output logic                           zero_out
);
  import cpa_pkg::*;

  localparam int ZW = 34;
  localparam int UW = CW - 1;

  logic signed [CW-1:0] xs [0:STEPS];
  logic signed [CW-1:0] ys [0:STEPS];
  logic [ZW-1:0] zs [0:STEPS];
  logic zf [0:STEPS];

  logic signed [CW-1:0] px, py;
  logic [ZW-1:0] pz;
  logic pzero, flip;
  logic [31:0] zr;

  always_comb begin
    flip = z_in[31] ^ z_in[30];
    zr = z_in ^ HALF_TURN;
    pzero = (x_in == '0) && (y_in == '0);
    if (VECTOR) begin
      if (x_in[CW-1]) begin
        px = -x_in;
        py = -y_in;
        pz = {2'b00, HALF_TURN};
      end else begin
        px = x_in;
        py = y_in;
        pz = '0;
      end
    end else begin
      px = flip ? -x_in : x_in;
      py = y_in;
      pz = flip ? {{2{zr[31]}}, zr} : {{2{z_in[31]}}, z_in};
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= px;
    ys[0] <= py;
    zs[0] <= pz;
    zf[0] <= pzero;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic up;
    logic signed [CW-1:0] dx, dy;
    logic [ZW-1:0] da;
    assign up = VECTOR ? ys[i][CW-1] : ~zs[i][ZW-1];
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = {2'b00, arc_tab(i)};
    always_ff @(posedge clk) begin
      if (up) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - da;
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + da;
      end
      zf[i+1] <= zf[i];
    end
  end

  // gain correction: abs, multiply, sum, restore sign
  logic signed [CW-1:0] lane [0:1];
  logic g1_s [0:1];
  logic [UW-1:0] g1_u [0:1];
  logic [63:0] lo_full [0:1];
  logic g2_s [0:1];
  logic [UW-1:0] g2_hi [0:1];
  logic [31:0] g2_lo [0:1];
  logic g3_s [0:1];
  logic [UW-1:0] g3_m [0:1];
  logic signed [CW-1:0] g4 [0:1];
  logic [31:0] zp [0:3];
  logic zfp [0:3];

  assign lane[0] = xs[STEPS];
  assign lane[1] = ys[STEPS];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lo_full[l] = 64'(g1_u[l][31:0]) * 64'(KGAIN);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      g1_s[l] <= lane[l][CW-1];
      g1_u[l] <= lane[l][CW-1] ? UW'(-lane[l]) : UW'(lane[l]);
      g2_s[l] <= g1_s[l];
      g2_hi[l] <= UW'(g1_u[l][UW-1:32]) * UW'(KGAIN);
      g2_lo[l] <= lo_full[l][63:32];
      g3_s[l] <= g2_s[l];
      g3_m[l] <= g2_hi[l] + UW'(g2_lo[l]);
      g4[l] <= g3_s[l] ? -$signed({1'b0, g3_m[l]}) : $signed({1'b0, g3_m[l]});
    end
    zp[0] <= zs[STEPS][31:0];
    zfp[0] <= zf[STEPS];
    for (int k = 1; k < 4; k++) begin
      zp[k] <= zp[k-1];
      zfp[k] <= zfp[k-1];
    end
  end

  assign x_out = g4[0];
  assign y_out = g4[1];
  assign z_out = zp[3];
  assign zero_out = zfp[3];

endmodule
`default_nettype wire

### design/cpa_div.sv
`default_nettype none
module cpa_div #(
  parameter int DW = 33 + cpa_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic [DW-1:0] num,
  input  logic [31:0]   den,
  output logic [DW-1:0] quo
);

  logic [31:0] rem [0:DW];
  logic [DW-1:0] nm [0:DW];
  logic [DW-1:0] qq [0:DW];
  logic [31:0] dd [0:DW];

  assign rem[0] = '0;
  assign nm[0] = num;
  assign qq[0] = '0;
  assign dd[0] = den;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DW; k++) begin : g_bit
    logic [32:0] t;
    logic ge;
    assign t = {rem[k], nm[k][DW-1]};
    assign ge = t >= {1'b0, dd[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? 32'(t - {1'b0, dd[k]}) : t[31:0];
      qq[k+1] <= {qq[k][DW-2:0], ge};
      nm[k+1] <= {nm[k][DW-2:0], 1'b0};
      dd[k+1] <= dd[k];
    end
  end

  assign quo = qq[DW];

endmodule
`default_nettype wire

### design/polar_complex_arith_unit.sv
`default_nettype none
// Fully pipelined polar complex arithmetic unit. A word is taken at every clock edge where
// start is high (busy is never raised), and its result appears on the res_* ports with done
// high for one cycle, after a delay that is the same for every action alike. The delay is set by the
// rotation and vectoring CORDIC chains that add and sub run in series, or by the
// one-bit-per-stage divider for inverse and div, whichever is longer. Results must be
// taken when done is high.
module polar_complex_arith_unit #(
  parameter int CORDIC_STEPS = cpa_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = cpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         action,
  input  logic [31:0]        a_mag,
  input  logic signed [31:0] a_angle,
  input  logic [31:0]        b_mag,
  input  logic signed [31:0] b_angle,
  input  logic signed [31:0] rect_re,
  input  logic signed [31:0] rect_im,
  output logic               done,
  output logic [31:0]        res_mag,
  output logic signed [31:0] res_angle,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               is_equal,
  output logic [1:0]         status
);
  import cpa_pkg::*;
  `include "polar_complex_arith_unit_macros.svh"

  localparam int DW = 33 + FRAC_BITS;
  localparam int CPI = 5 + CORDIC_STEPS;
  localparam int CMB = CPI + 1;
  localparam int VPI = CMB + 5 + CORDIC_STEPS;
  localparam int VUG = VPI + 1;
  localparam int DVI = 1 + DW;
  localparam int LF = (VUG > DVI ? VUG : DVI) + 1;
  localparam int RES_IDX = LF + 1;
  localparam int TR_N = LF - CMB;
  localparam int VL_N = LF - VPI;
  localparam int DV_N = LF - DVI;
  localparam int UGW = CW - GUARD;
  localparam logic [64:0] MUL_HALF = 65'(1) << (FRAC_BITS - 1);

  assign busy = 1'b0;

  // input word
  logic s0_v;
  logic [3:0] s0_act;
  logic [31:0] s0_am, s0_aa, s0_bm, s0_ba, s0_re, s0_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= start && !busy;
    end
    s0_act <= action;
    s0_am <= a_mag;
    s0_aa <= a_angle;
    s0_bm <= b_mag;
    s0_ba <= b_angle;
    s0_re <= rect_re;
    s0_im <= rect_im;
  end

  // direct ops and control line
  cpa_ctrl_t ctrl_in;
  cpa_ctrl_t ctrl_line [0:LF-1];
  logic vld [0:LF-1];
  logic [63:0] rect_line [0:CPI-1];

  always_comb begin
    ctrl_in.act = s0_act;
    ctrl_in.prod = 64'(s0_am) * 64'(s0_bm);
    ctrl_in.mag = s0_am;
    ctrl_in.eq = (s0_am == s0_bm) && (s0_aa == s0_ba);
    ctrl_in.dz = (s0_act == ACT_INVERSE) ? (s0_am == '0) : (s0_bm == '0);
    unique case (s0_act)
      ACT_CONJ, ACT_INVERSE: ctrl_in.ang = 32'd0 - s0_aa;
      ACT_NEGATE: ctrl_in.ang = s0_aa + HALF_TURN;
      ACT_MUL: ctrl_in.ang = s0_aa + s0_ba;
      ACT_DIV: ctrl_in.ang = s0_aa - s0_ba;
      default: ctrl_in.ang = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LF; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= s0_v;
      for (int k = 1; k < LF; k++) vld[k] <= vld[k-1];
    end
    ctrl_line[0] <= ctrl_in;
    for (int k = 1; k < LF; k++) ctrl_line[k] <= ctrl_line[k-1];
    rect_line[0] <= {s0_re, s0_im};
    for (int k = 1; k < CPI; k++) rect_line[k] <= rect_line[k-1];
  end

  // divider for inverse and div
  logic [DW-1:0] dv_num, dv_quo;
  logic [31:0] dv_den;
  logic [DW-1:0] dv_line [0:DV_N-1];

  always_ff @(posedge clk) begin
    if (s0_act == ACT_INVERSE) begin
      dv_num <= (DW'(1) << (2 * FRAC_BITS)) + DW'(s0_am >> 1);
      dv_den <= s0_am;
    end else begin
      dv_num <= (DW'(s0_am) << FRAC_BITS) + DW'(s0_bm >> 1);
      dv_den <= s0_bm;
    end
  end

  cpa_div #(.DW(DW)) u_div (
    .clk(clk), .num(dv_num), .den(dv_den), .quo(dv_quo)
  );

  always_ff @(posedge clk) begin
    dv_line[0] <= dv_quo;
    for (int k = 1; k < DV_N; k++) dv_line[k] <= dv_line[k-1];
  end

  // rotation of both operands
  logic signed [CW-1:0] ra_x, ra_y, rb_x, rb_y;

  cpa_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_a (
    .clk(clk),
    .x_in($signed({{(CW-32-GUARD){1'b0}}, s0_am, {GUARD{1'b0}}})),
    .y_in('0), .z_in(s0_aa),
    .x_out(ra_x), .y_out(ra_y), .z_out(), .zero_out()
  );

  cpa_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_b (
    .clk(clk),
    .x_in($signed({{(CW-32-GUARD){1'b0}}, s0_bm, {GUARD{1'b0}}})),
    .y_in('0), .z_in(s0_ba),
    .x_out(rb_x), .y_out(rb_y), .z_out(), .zero_out()
  );

  // combine stage
  logic [3:0] cmb_act;
  logic [31:0] cr_re, cr_im;
  logic signed [CW-1:0] cr_x, cr_y, cmb_x, cmb_y;
  logic signed [UGW-1:0] ug_re, ug_im;
  logic signed [CW-1:0] ra_xr, ra_yr;
  logic signed [UGW-1:0] tr_re [0:TR_N-1];
  logic signed [UGW-1:0] tr_im [0:TR_N-1];

  assign cmb_act = ctrl_line[CPI-1].act;
  assign cr_re = rect_line[CPI-1][63:32];
  assign cr_im = rect_line[CPI-1][31:0];
  assign cr_x = $signed({{(CW-32-GUARD){cr_re[31]}}, cr_re, {GUARD{1'b0}}});
  assign cr_y = $signed({{(CW-32-GUARD){cr_im[31]}}, cr_im, {GUARD{1'b0}}});
  // round half away from zero
  assign ra_xr = ra_x + $signed(CW'({1'b0, {(GUARD-1){1'b1}}}) + CW'(!ra_x[CW-1]));
  assign ra_yr = ra_y + $signed(CW'({1'b0, {(GUARD-1){1'b1}}}) + CW'(!ra_y[CW-1]));

  always_ff @(posedge clk) begin
    if (cmb_act == ACT_FROM_RECT) begin
      cmb_x <= cr_x;
      cmb_y <= cr_y;
    end else if (cmb_act == ACT_SUB) begin
      cmb_x <= ra_x - rb_x;
      cmb_y <= ra_y - rb_y;
    end else begin
      cmb_x <= ra_x + rb_x;
      cmb_y <= ra_y + rb_y;
    end
    ug_re <= ra_xr[CW-1:GUARD];
    ug_im <= ra_yr[CW-1:GUARD];
    tr_re[0] <= ug_re;
    tr_im[0] <= ug_im;
    for (int k = 1; k < TR_N; k++) begin
      tr_re[k] <= tr_re[k-1];
      tr_im[k] <= tr_im[k-1];
    end
  end

  // vectoring back to polar
  logic signed [CW-1:0] v_x;
  logic [31:0] v_z;
  logic v_zero;
  logic [CW-1:0] v_xr;
  logic [UGW-1:0] vl_m [0:VL_N-1];
  logic [31:0] vl_z [0:VL_N-1];
  logic vl_zero [0:VL_N-1];

  cpa_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
    .clk(clk), .x_in(cmb_x), .y_in(cmb_y), .z_in('0),
    .x_out(v_x), .y_out(), .z_out(v_z), .zero_out(v_zero)
  );

  assign v_xr = v_x + CW'({1'b1, {(GUARD-1){1'b0}}});

  always_ff @(posedge clk) begin
    vl_m[0] <= v_xr[CW-1:GUARD];
    vl_z[0] <= v_z;
    vl_zero[0] <= v_zero;
    for (int k = 1; k < VL_N; k++) begin
      vl_m[k] <= vl_m[k-1];
      vl_z[k] <= vl_z[k-1];
      vl_zero[k] <= vl_zero[k-1];
    end
  end

  // final select and saturation
  function automatic logic [32:0] sat_part(input logic signed [UGW-1:0] v);
    logic [32:0] r;
    if (!v[UGW-1] && (v[UGW-2:31] != '0)) r = {1'b1, 32'h7FFF_FFFF};
    else if (v[UGW-1] && (v[UGW-2:31] != '1)) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  cpa_ctrl_t fc;
  logic [UGW-1:0] fm;
  logic [31:0] fz;
  logic fzero;
  logic [DW-1:0] fq;
  logic [64:0] mr;
  logic [32:0] sre, sim;
  logic [31:0] m_n, a_n, re_n, im_n;
  logic eq_n;
  logic [1:0] st_n;

  assign fc = ctrl_line[LF-1];
  assign fm = vl_m[VL_N-1];
  assign fz = vl_z[VL_N-1];
  assign fzero = vl_zero[VL_N-1];
  assign fq = dv_line[DV_N-1];
  assign mr = ({1'b0, fc.prod} + MUL_HALF) >> FRAC_BITS;
  assign sre = sat_part(tr_re[TR_N-1]);
  assign sim = sat_part(tr_im[TR_N-1]);

  always_comb begin
    m_n = '0;
    a_n = '0;
    re_n = '0;
    im_n = '0;
    eq_n = 1'b0;
    st_n = ST_OK;
    unique case (fc.act)
      ACT_FROM_RECT: begin
        m_n = fm[31:0];
        a_n = fzero ? 32'd0 : fz;
      end
      ACT_TO_RECT: begin
        re_n = sre[31:0];
        im_n = sim[31:0];
        if (sre[32] || sim[32]) st_n = ST_SAT;
      end
      ACT_EQUAL: eq_n = fc.eq;
      ACT_CONJ, ACT_NEGATE: begin
        m_n = fc.mag;
        a_n = fc.ang;
      end
      ACT_INVERSE, ACT_DIV: begin
        a_n = fc.ang;
        if (fc.dz) begin
          m_n = M32;
          st_n = ST_DIVZ;
        end else if (fq[DW-1:32] != '0) begin
          m_n = M32;
          st_n = ST_SAT;
        end else begin
          m_n = fq[31:0];
        end
      end
      ACT_ADD, ACT_SUB: begin
        a_n = fzero ? 32'd0 : fz;
        if (fm[UGW-1:32] != '0) begin
          m_n = M32;
          st_n = ST_SAT;
        end else begin
          m_n = fm[31:0];
        end
      end
      ACT_MUL: begin
        a_n = fc.ang;
        if (mr[64:32] != '0) begin
          m_n = M32;
          st_n = ST_SAT;
        end else begin
          m_n = mr[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LF-1];
    end
    res_mag <= m_n;
    res_angle <= a_n;
    res_re <= re_n;
    res_im <= im_n;
    is_equal <= eq_n;
    status <= st_n;
  end

  `CPA_ASSERT_PAST(a_done_from_start, done, start && !busy, RES_IDX + 1)
  `CPA_ASSERT_PAST(a_divz_action, done && (status == ST_DIVZ),
                   (action == ACT_INVERSE) || (action == ACT_DIV), RES_IDX + 1)
  `CPA_ASSERT_PAST(a_equal_action, done && is_equal, action == ACT_EQUAL, RES_IDX + 1)
  `CPA_ASSERT_IMPL(a_rect_only_to_rect, done && ((res_re != '0) || (res_im != '0)),
                   (res_mag == '0) && (res_angle == '0) && !is_equal)

endmodule
`default_nettype wire
